[src/bitmap_block_allocator_defines.svh]
// Assertion macros shared by the allocator's checker.
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define BBA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bitmap allocator check failed");

// Next-cycle implication that also holds across reset.
`define BBA_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("bitmap allocator check failed");

`endif

[src/bba_pkg.sv]
// Types, codes and helper functions of the bitmap block allocator.
package bba_pkg;

   localparam int WORD_W = 32;
   localparam int COUNT_W = 13;
   localparam int COUNT_MAX = 8191;
   localparam int BLOCK_W = 17;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NOFREE = 2'd1;
   localparam logic [1:0] STATUS_BELOW = 2'd2;
   localparam logic [1:0] STATUS_BEYOND = 2'd3;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE = 1'b1;

   localparam logic REG_TOTAL = 1'b0;
   localparam logic REG_BASE = 1'b1;

   localparam logic [12:0] TOTAL_RESET = 13'd4096;
   localparam logic [15:0] BASE_RESET = 16'd36;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE_RD,
      S_FREE_WR
   } state_type;

   // Position of the lowest clear bit; only meaningful when one exists.
   function automatic logic [4:0] first_clear(input logic [WORD_W-1:0] word);
      logic [4:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!word[i]) begin
            pos = 5'(i);
         end
      end
      return pos;
   endfunction

endpackage

[src/bitmap_block_allocator.sv]
// Bitmap first-fit block allocator: used-block map in a word memory plus free count.
//
// Requests: an item transfers at a rising edge with start high and busy low.
// req_type selects allocate or free; req_free_block_number is used on free only.
// Results: exactly one per request, shown for one cycle with rsp_strobe high;
// the receiver has no way to stall them.
// Request kinds:
//   - allocate with a zero free count, free below the base or beyond the total:
//     result in the cycle after the transfer, busy never rises.
//   - free: the result follows a read, modify and write of one map word
//     (states S_FREE_RD, then S_FREE_WR).
//   - allocate: the map is read one 32-bit word per cycle from word 0, each read
//     one word ahead of the check, until a check finds the first clear bit;
//     the result follows that check. A scan that finds no clear bit ends once
//     every word within the usable total has been read and checked; busy stays
//     high during the scan.
// Reset: a clearing pass writes every map word to zero, one word per cycle;
// busy stays high during it. Register writes on the APB port are taken at any
// time; a write during a scan changes the limit and base that the scan uses.
module bitmap_block_allocator
   import bba_pkg::*;
#(
   parameter int NBLOCKS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [31:0] req_free_block_number,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [16:0] rsp_block_number,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int ROWS = (NBLOCKS + WORD_W - 1) / WORD_W;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CNT_W = $clog2(ROWS + 1);
   localparam int FIDX_W = ROW_W + 5;
   localparam int FC_RESET = (NBLOCKS > COUNT_MAX) ? COUNT_MAX : NBLOCKS;

   logic [WORD_W-1:0] map_mem [ROWS];

   state_type state_ff, state_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] lim_rows_ff, lim_rows_in;
   logic chk_vld_ff, chk_vld_in;
   logic [ROW_W-1:0] chk_row_ff, chk_row_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic [FIDX_W-1:0] free_idx_ff, free_idx_in;
   logic [COUNT_W-1:0] free_count_ff, free_count_in;
   logic [12:0] total_ff, total_in;
   logic [15:0] base_ff, base_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [16:0] rsp_block_ff, rsp_block_in;

   logic mem_rd_en;
   logic [ROW_W-1:0] mem_rd_addr;
   logic mem_wr_en;
   logic [ROW_W-1:0] mem_wr_addr;
   logic [WORD_W-1:0] mem_wr_data;

   logic cfg_write;
   logic [31:0] limit;
   logic [31:0] lim_row;
   logic [WORD_W-1:0] valid_mask;
   logic [WORD_W-1:0] masked_word;
   logic word_hit;
   logic [4:0] hit_pos;
   logic [32:0] free_diff;
   logic scan_issue;

   // Usable total is capped at the map size.
   assign limit = (32'(total_ff) > 32'(NBLOCKS)) ? 32'(NBLOCKS) : 32'(total_ff);
   assign lim_row = limit >> 5;

   // Bits at or above the usable total count as used while scanning.
   assign valid_mask = (32'(chk_row_ff) < lim_row) ? '1 :
                       ((32'd1 << limit[4:0]) - 32'd1);
   assign masked_word = rd_data_ff | ~valid_mask;
   assign word_hit = ~&masked_word;
   assign hit_pos = first_clear(masked_word);

   assign free_diff = {1'b0, req_free_block_number} - {17'd0, base_ff};
   assign scan_issue = (row_ff < lim_rows_ff);

   assign cfg_write = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_BASE) ? {16'd0, base_ff} : {19'd0, total_ff};

   always_comb begin
      total_in = total_ff;
      base_in = base_ff;
      if (cfg_write) begin
         unique case (paddr[2])
            REG_TOTAL: total_in = pwdata[12:0];
            REG_BASE:  base_in = pwdata[15:0];
            default:   total_in = total_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      lim_rows_in = lim_rows_ff;
      chk_vld_in = 1'b0;
      chk_row_in = row_ff[ROW_W-1:0];
      free_idx_in = free_idx_ff;
      free_count_in = free_count_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_block_in = rsp_block_ff;
      mem_rd_en = 1'b0;
      mem_rd_addr = row_ff[ROW_W-1:0];
      mem_wr_en = 1'b0;
      mem_wr_addr = row_ff[ROW_W-1:0];
      mem_wr_data = '0;
      busy = (state_ff != S_IDLE);

      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en = 1'b1;
            if (row_ff == CNT_W'(ROWS - 1)) begin
               row_in = '0;
               state_in = S_IDLE;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (start) begin
               rsp_block_in = '0;
               if (req_type == REQ_ALLOC) begin
                  if (free_count_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_status_in = STATUS_NOFREE;
                  end else begin
                     row_in = '0;
                     lim_rows_in = CNT_W'((limit + 32'd31) >> 5);
                     state_in = S_SCAN;
                  end
               end else if (free_diff[32]) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = STATUS_BELOW;
               end else if (free_diff[31:0] >= limit) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = STATUS_BEYOND;
               end else begin
                  free_idx_in = free_diff[FIDX_W-1:0];
                  if (free_count_ff != COUNT_W'(COUNT_MAX)) begin
                     free_count_in = free_count_ff + 1'b1;
                  end
                  state_in = S_FREE_RD;
               end
            end
         end
         S_SCAN: begin
            // Reads run one word ahead of the check of the previous word.
            mem_rd_en = scan_issue;
            chk_vld_in = scan_issue;
            if (scan_issue) begin
               row_in = row_ff + 1'b1;
            end
            if (chk_vld_ff && word_hit) begin
               mem_wr_en = 1'b1;
               mem_wr_addr = chk_row_ff;
               mem_wr_data = rd_data_ff | (32'd1 << hit_pos);
               free_count_in = free_count_ff - 1'b1;
               rsp_valid_in = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_block_in = 17'({chk_row_ff, hit_pos}) + 17'(base_ff);
               state_in = S_IDLE;
            end else if (!chk_vld_ff && !scan_issue) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STATUS_NOFREE;
               state_in = S_IDLE;
            end
         end
         S_FREE_RD: begin
            mem_rd_en = 1'b1;
            mem_rd_addr = free_idx_ff[FIDX_W-1:5];
            state_in = S_FREE_WR;
         end
         S_FREE_WR: begin
            mem_wr_en = 1'b1;
            mem_wr_addr = free_idx_ff[FIDX_W-1:5];
            mem_wr_data = rd_data_ff & ~(32'd1 << free_idx_ff[4:0]);
            rsp_valid_in = 1'b1;
            rsp_status_in = STATUS_OK;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         row_ff <= '0;
         lim_rows_ff <= '0;
         chk_vld_ff <= 1'b0;
         free_count_ff <= COUNT_W'(FC_RESET);
         total_ff <= TOTAL_RESET;
         base_ff <= BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         lim_rows_ff <= lim_rows_in;
         chk_vld_ff <= chk_vld_in;
         free_count_ff <= free_count_in;
         total_ff <= total_in;
         base_ff <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_row_ff <= chk_row_in;
      free_idx_ff <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff <= rsp_block_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         map_mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_data_ff <= map_mem[mem_rd_addr];
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_block_number = rsp_block_ff;

endmodule

[src/bba_checker.sv]
// Port-level checks of the bitmap block allocator and their binding.
`include "bitmap_block_allocator_defines.svh"

module bba_checker
   import bba_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_status,
   input logic [16:0] rsp_block_number
);

   // Reset starts the clearing pass, so no request is taken right after it.
   `BBA_ASSERT_NEXT(a_reset_busy, clock, reset, busy)

   // Only a successful allocate carries a block number.
   `BBA_ASSERT_IMPL(a_fail_zero, clock, reset, rsp_strobe && rsp_status != STATUS_OK, rsp_block_number == 17'd0)

   // A result follows either a transfer or a cycle of work on one.
   `BBA_ASSERT_IMPL(a_result_cause, clock, reset, rsp_strobe, $past(busy) || $past(start))

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_status       (rsp_status),
   .rsp_block_number (rsp_block_number)
);

[verif/bba_alloc_checker.sv]
// Watches the allocator's request, result and register ports and checks every result.
`timescale 1ns / 100ps

module bba_alloc_checker
   import bba_pkg::*;
#(
   parameter int NBLOCKS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_type,
   input  logic [31:0] req_free_block_number,
   input  logic        rsp_strobe,
   input  logic [1:0]  rsp_status,
   input  logic [16:0] rsp_block_number,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          mismatch_count,
   output int          outstanding
);

   localparam int COUNT_CAP = (NBLOCKS > COUNT_MAX) ? COUNT_MAX : NBLOCKS;

   typedef struct packed {
      logic [1:0]         status;
      logic [BLOCK_W-1:0] block_number;
   } reply_type;

   bit                 used_blocks [NBLOCKS];
   logic [COUNT_W-1:0] free_left;
   logic [12:0]        total_reg;
   logic [15:0]        base_reg;
   reply_type          expected_replies [$];
   reply_type          want;

   // Applies one request to the local copy of the map and returns its result.
   function automatic reply_type model_request(input logic kind, input logic [31:0] blk_in);
      reply_type   r;
      int unsigned lim;
      int unsigned idx;
      logic [31:0] offset;
      lim = (total_reg > NBLOCKS) ? NBLOCKS : total_reg;
      r.status = STATUS_OK;
      r.block_number = '0;
      if (kind == REQ_ALLOC) begin
         idx = 0;
         while (idx < lim && used_blocks[idx]) idx++;
         if (free_left == '0 || idx == lim) begin
            r.status = STATUS_NOFREE;
         end else begin
            used_blocks[idx] = 1'b1;
            free_left = free_left - 1'b1;
            r.block_number = BLOCK_W'(idx + base_reg);
         end
      end else if (blk_in < base_reg) begin
         r.status = STATUS_BELOW;
      end else begin
         offset = blk_in - base_reg;
         if (offset >= lim) begin
            r.status = STATUS_BEYOND;
         end else begin
            // A block that is already clear still counts as freed.
            used_blocks[offset] = 1'b0;
            if (free_left < COUNT_MAX) free_left = free_left + 1'b1;
         end
      end
      return r;
   endfunction

   task automatic log_mismatch(input string what, input int exp_val, input int act_val);
      if (mismatch_count < 10) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, act_val);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (used_blocks[i]) used_blocks[i] = 1'b0;
         free_left = COUNT_W'(COUNT_CAP);
         total_reg = TOTAL_RESET;
         base_reg = BASE_RESET;
         expected_replies.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_replies.size() == 0) begin
               log_mismatch("unexpected result status", -1, rsp_status);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status) begin
                  log_mismatch("status", want.status, rsp_status);
               end
               if (rsp_block_number !== want.block_number) begin
                  log_mismatch("block_number", want.block_number, rsp_block_number);
               end
            end
         end
         if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_TOTAL) begin
               total_reg = pwdata[12:0];
            end else begin
               base_reg = pwdata[15:0];
            end
         end
         if (start && !busy) begin
            expected_replies.push_back(model_request(req_type, req_free_block_number));
         end
      end
      outstanding = expected_replies.size();
   end

endmodule

[verif/tb_bitmap_block_allocator.sv]
// Testbench top for the bitmap block allocator: reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_bitmap_block_allocator;
   import bba_pkg::*;

   localparam int NBLOCKS = 4096;
   localparam int STALL_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        req_type = REQ_ALLOC;
   logic [31:0] req_free_block_number = '0;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [16:0] rsp_block_number;
   logic [31:0] prdata;
   logic        pready;

   int          mismatch_count;
   int          outstanding;
   int          stall_cycles = 0;
   int          idle_pct = 37;
   logic [12:0] cur_total = TOTAL_RESET;
   logic [15:0] cur_base = BASE_RESET;

   always #1 clock = ~clock;

   bitmap_block_allocator #(.NBLOCKS(NBLOCKS)) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_type              (req_type),
      .req_free_block_number (req_free_block_number),
      .rsp_strobe            (rsp_strobe),
      .rsp_status            (rsp_status),
      .rsp_block_number      (rsp_block_number),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   bba_alloc_checker #(.NBLOCKS(NBLOCKS)) i_checker (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_type              (req_type),
      .req_free_block_number (req_free_block_number),
      .rsp_strobe            (rsp_strobe),
      .rsp_status            (rsp_status),
      .rsp_block_number      (rsp_block_number),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .pready                (pready),
      .mismatch_count        (mismatch_count),
      .outstanding           (outstanding)
   );

   // Any transfer, result or register access counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || psel) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles == STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // All tasks are entered and left at a falling edge.
   task automatic send_item(input logic kind, input logic [31:0] blk);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      start <= 1'b1;
      req_type <= kind;
      req_free_block_number <= blk;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0 || busy);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Upper data bits are random; the block must ignore them.
   task automatic set_config(input logic [12:0] total, input logic [15:0] base);
      drain();
      write_reg(REG_TOTAL, {19'($urandom()), total});
      write_reg(REG_BASE, {16'($urandom()), base});
      cur_total = total;
      cur_base = base;
   endtask

   // Most frees land in or just past the map window so that blocks cycle.
   task automatic random_item();
      int unsigned lim;
      int unsigned pick;
      logic [31:0] blk;
      lim = (cur_total > NBLOCKS) ? NBLOCKS : cur_total;
      pick = $urandom_range(99);
      blk = $urandom();
      if (pick < 50) begin
         send_item(REQ_ALLOC, blk);
      end else begin
         if (pick < 85) begin
            blk = cur_base + $urandom_range(lim + 2);
         end else if (pick < 92 && cur_base != 0) begin
            blk = $urandom_range(cur_base - 1);
         end
         send_item(REQ_FREE, blk);
      end
   endtask

   task automatic run_phase(input logic [12:0] total, input logic [15:0] base, input int n);
      set_config(total, base);
      repeat (n) random_item();
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      send_item(REQ_ALLOC, 32'h0);
      send_item(REQ_FREE, 32'd35);
      send_item(REQ_FREE, 32'd0);
      send_item(REQ_FREE, 32'd36 + NBLOCKS);
      send_item(REQ_FREE, 32'hFFFF_FFFF);
      send_item(REQ_FREE, 32'd36);
      send_item(REQ_FREE, 32'd36);
      send_item(REQ_FREE, 32'd36 + NBLOCKS - 1);
      send_item(REQ_ALLOC, 32'hFFFF_FFFF);
      send_item(REQ_ALLOC, 32'h0);
      // The double free left the count above the number of clear blocks.
      send_item(REQ_ALLOC, 32'h0);

      // A total above the map size is clipped to the map size.
      set_config(13'd8191, 16'd65535);
      send_item(REQ_FREE, 32'd65535 + NBLOCKS - 1);
      send_item(REQ_ALLOC, 32'h0);
      send_item(REQ_FREE, 32'd65534);
      send_item(REQ_FREE, 32'd65535 + NBLOCKS);
      send_item(REQ_FREE, 32'd65535);
      send_item(REQ_ALLOC, 32'h0);

      set_config(13'd0, 16'd0);
      send_item(REQ_ALLOC, 32'h0);
      send_item(REQ_FREE, 32'd0);

      run_phase(13'd40, 16'd0, 120);
      run_phase(13'd8, 16'd36, 100);
      idle_pct = 0;
      run_phase(13'd100, 16'd12345, 120);
      idle_pct = 37;
      run_phase(13'd4096, 16'd36, 100);
      run_phase(13'd8191, 16'd65535, 60);
      run_phase(13'd0, 16'd500, 30);
      run_phase(13'd1, 16'd7, 60);
      run_phase(13'd4095, 16'd65535, 60);

      drain();
      repeat (150) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
